/* hw/rtl/chbd_pkg.sv */
// ----------------------------------------------------------------------------
// chbd_pkg
// Shared types, constants and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package chbd_pkg;

    localparam int SIZE_DIGITS   = 4;
    localparam int DIGIT_CNT_W   = $clog2(SIZE_DIGITS + 1);
    localparam int SIZE_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int USER_W        = 3;

    localparam logic [BYTE_W-1:0] BYTE_CR = 8'd13;
    localparam logic [BYTE_W-1:0] BYTE_LF = 8'd10;
    localparam logic [1:0]        TRAILER_BYTES = 2'd2;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SIZE   = 5'b00010,
        PH_DATA   = 5'b00100,
        PH_SKIP   = 5'b01000,
        PH_STOP   = 5'b10000
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic                   last_was_cr;
        logic [1:0]             line_end_count;
        logic [SIZE_W-1:0]      size_acc;
        logic [DIGIT_CNT_W-1:0] digits_read;
        logic                   hex_stopped;
        logic [SIZE_W-1:0]      bytes_remaining;
        logic [1:0]             skip_left;
    } state_t;

    // decoder state after reset: header skipping, all counters clear
    localparam state_t STATE_RESET = '{
        phase:           PH_HEADER,
        last_was_cr:     1'b0,
        line_end_count:  2'd0,
        size_acc:        '0,
        digits_read:     '0,
        hex_stopped:     1'b0,
        bytes_remaining: '0,
        skip_left:       2'd0
    };

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              chunk_last;
        logic              body_done;
        logic              format_error;
    } result_t;

    // ASCII hex digit decode: {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [BYTE_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

/* hw/rtl/http_chunked_body_decoder_core.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Strips the header and chunk framing from an HTTP response byte stream.
// ----------------------------------------------------------------------------
// The result is registered: it reaches the master side in the cycle after the input transfer.
// Throughput: 1 byte per cycle while the master side accepts results.
// s_tready stays high while the result register is empty or being drained.
// Reset (rst_n low, async): decoder returns to header skipping, output empty.
module http_chunked_body_decoder_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [chbd_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [chbd_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] payload_byte
    output logic [chbd_pkg::USER_W-1:0]    m_tuser,   // [0] payload_valid,
                                                      // [1] body_done, [2] format_error
    output logic                           m_tlast    // chunk_last
);

    chbd_pkg::state_t  state_reg;
    chbd_pkg::state_t  state_next;
    chbd_pkg::result_t res;
    logic              m_tvalid_reg;
    logic [chbd_pkg::BYTE_W-1:0] m_tdata_reg;
    logic [chbd_pkg::USER_W-1:0] m_tuser_reg;
    logic              m_tlast_reg;
    logic              in_xfer;

    chbd_step u_step
    (
        .cur       (state_reg),
        .data_byte (s_tdata),
        .nxt       (state_next),
        .res       (res)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= chbd_pkg::STATE_RESET;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (in_xfer)
                state_reg <= state_next;
            if (in_xfer)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            m_tdata_reg <= res.payload_byte;
            m_tuser_reg <= {res.format_error, res.body_done, res.payload_valid};
            m_tlast_reg <= res.chunk_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* hw/rtl/chbd_step.sv */
// ----------------------------------------------------------------------------
// chbd_step
// Next-state and result logic for one received byte.
// ----------------------------------------------------------------------------
module chbd_step
(
    input  chbd_pkg::state_t                  cur,
    input  logic [chbd_pkg::BYTE_W-1:0]       data_byte,
    output chbd_pkg::state_t                  nxt,
    output chbd_pkg::result_t                 res
);

    logic                         is_cr;
    logic                         is_lf;
    logic [4:0]                   hex;
    logic [chbd_pkg::SIZE_W+3:0]  shifted;
    logic                         track;

    assign is_cr   = (data_byte == chbd_pkg::BYTE_CR);
    assign is_lf   = (data_byte == chbd_pkg::BYTE_LF);
    assign hex     = chbd_pkg::hex_decode(data_byte);
    assign shifted = {cur.size_acc, hex[3:0]};

    always_comb
    begin
        nxt   = cur;
        res   = '0;
        track = 1'b1;
        case (cur.phase)
            chbd_pkg::PH_HEADER:
            begin
                if (cur.last_was_cr && is_lf)
                    nxt.line_end_count = cur.line_end_count + 2'd1;
                else if (!is_cr)
                    nxt.line_end_count = 2'd0;
                if (nxt.line_end_count == 2'd2)
                begin
                    nxt.line_end_count = 2'd0;
                    nxt.size_acc       = '0;
                    nxt.digits_read    = '0;
                    nxt.hex_stopped    = 1'b0;
                    nxt.phase          = chbd_pkg::PH_SIZE;
                end
            end
            chbd_pkg::PH_SIZE:
            begin
                if (!is_cr && !is_lf)
                begin
                    if (cur.hex_stopped)
                        ;
                    else if (!hex[4])
                        nxt.hex_stopped = 1'b1;
                    else if (cur.digits_read < chbd_pkg::DIGIT_CNT_W'(chbd_pkg::SIZE_DIGITS))
                    begin
                        // saturate when the shifted value overflows 16 bits
                        if (shifted[chbd_pkg::SIZE_W+3:chbd_pkg::SIZE_W] != 4'd0)
                            nxt.size_acc = '1;
                        else
                            nxt.size_acc = shifted[chbd_pkg::SIZE_W-1:0];
                        nxt.digits_read = cur.digits_read + 1'b1;
                    end
                    else
                        res.format_error = 1'b1;
                end
                else if (is_lf && cur.last_was_cr)
                begin
                    if (cur.digits_read == '0)
                    begin
                        res.format_error = 1'b1;
                        nxt.phase        = chbd_pkg::PH_STOP;
                    end
                    else if (cur.size_acc == '0)
                    begin
                        res.body_done = 1'b1;
                        nxt.phase     = chbd_pkg::PH_STOP;
                    end
                    else
                    begin
                        nxt.bytes_remaining = cur.size_acc;
                        nxt.phase           = chbd_pkg::PH_DATA;
                    end
                    nxt.size_acc    = '0;
                    nxt.digits_read = '0;
                    nxt.hex_stopped = 1'b0;
                end
            end
            chbd_pkg::PH_DATA:
            begin
                res.payload_valid = 1'b1;
                res.payload_byte  = data_byte;
                if (cur.bytes_remaining <= chbd_pkg::SIZE_W'(1))
                begin
                    nxt.bytes_remaining = '0;
                    res.chunk_last      = 1'b1;
                    nxt.skip_left       = chbd_pkg::TRAILER_BYTES;
                    nxt.phase           = chbd_pkg::PH_SKIP;
                end
                else
                    nxt.bytes_remaining = cur.bytes_remaining - 1'b1;
            end
            chbd_pkg::PH_SKIP:
            begin
                track = 1'b0;
                if (cur.skip_left <= 2'd1)
                begin
                    nxt.skip_left   = 2'd0;
                    nxt.size_acc    = '0;
                    nxt.digits_read = '0;
                    nxt.hex_stopped = 1'b0;
                    nxt.phase       = chbd_pkg::PH_SIZE;
                end
                else
                    nxt.skip_left = cur.skip_left - 2'd1;
            end
            default:
            begin
                track = 1'b0;
            end
        endcase
        if (track)
            nxt.last_was_cr = is_cr;
    end

endmodule

/* hw/rtl/chbd_checker.sv */
// ----------------------------------------------------------------------------
// chbd_checker
// Port-level checks for the chunked body decoder.
// ----------------------------------------------------------------------------
module chbd_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [chbd_pkg::BYTE_W-1:0]    s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [chbd_pkg::BYTE_W-1:0]    m_tdata,
    input logic [chbd_pkg::USER_W-1:0]    m_tuser,
    input logic                           m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    // an empty result register never stalls the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // chunk end only on a payload byte
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("tlast without payload");

    // non-payload results carry a zero byte
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("nonzero data on non-payload transfer");

    // an accepted byte produces a result on the next cycle
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("missing result after input transfer");

endmodule

bind http_chunked_body_decoder_core chbd_checker u_chbd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/sv/chbd_decode_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chbd_decode_checker
// Watches both stream ports of the chunked body decoder. It decodes every
// accepted input byte in a software copy of the decoder and compares each
// output transfer, field by field, with the oldest decoded result waiting.
// ----------------------------------------------------------------------------
module chbd_decode_checker
    import chbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [BYTE_W-1:0] m_tdata,
    input  logic [USER_W-1:0] m_tuser,
    input  logic              m_tlast,
    output int                pending,
    output int                errors
);

    // decoder copy
    phase_t                 ph;
    logic                   cr_seen;
    logic [1:0]             crlf_run;
    logic [SIZE_W-1:0]      size_val;
    logic [DIGIT_CNT_W-1:0] ndigits;
    logic                   hex_done;
    logic [SIZE_W-1:0]      left_in_chunk;
    logic [1:0]             trailer_left;

    result_t decoded_q[$];
    result_t want;

    function automatic void restart_size_line();
        size_val = '0;
        ndigits  = '0;
        hex_done = 1'b0;
    endfunction

    function automatic result_t decode_byte(input logic [BYTE_W-1:0] b);
        result_t           r;
        logic              track;
        int                nib;
        logic [SIZE_W+3:0] grown;
        r     = '0;
        track = 1'b1;
        if (b >= "0" && b <= "9")
            nib = b - "0";
        else if (b >= "a" && b <= "f")
            nib = b - "a" + 10;
        else if (b >= "A" && b <= "F")
            nib = b - "A" + 10;
        else
            nib = -1;
        case (ph)
            PH_HEADER:
            begin
                if (cr_seen && b == BYTE_LF)
                    crlf_run = crlf_run + 2'd1;
                else if (b != BYTE_CR)
                    crlf_run = 2'd0;
                if (crlf_run == 2'd2)
                begin
                    crlf_run = 2'd0;
                    restart_size_line();
                    ph = PH_SIZE;
                end
            end
            PH_SIZE:
            begin
                if (b != BYTE_CR && b != BYTE_LF)
                begin
                    // once a non-hex byte shows up the rest of the line is ignored
                    if (!hex_done)
                    begin
                        if (nib < 0)
                            hex_done = 1'b1;
                        else if (ndigits < SIZE_DIGITS)
                        begin
                            grown    = {size_val, 4'(nib)};
                            size_val = (grown > 20'hFFFF) ? '1 : grown[SIZE_W-1:0];
                            ndigits  = ndigits + 1'b1;
                        end
                        else
                            r.format_error = 1'b1;
                    end
                end
                else if (b == BYTE_LF && cr_seen)
                begin
                    if (ndigits == 0)
                    begin
                        r.format_error = 1'b1;
                        ph = PH_STOP;
                    end
                    else if (size_val == 0)
                    begin
                        r.body_done = 1'b1;
                        ph = PH_STOP;
                    end
                    else
                    begin
                        left_in_chunk = size_val;
                        ph = PH_DATA;
                    end
                    restart_size_line();
                end
            end
            PH_DATA:
            begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                if (left_in_chunk <= 1)
                begin
                    left_in_chunk = '0;
                    r.chunk_last  = 1'b1;
                    trailer_left  = TRAILER_BYTES;
                    ph = PH_SKIP;
                end
                else
                    left_in_chunk = left_in_chunk - 1'b1;
            end
            PH_SKIP:
            begin
                // trailer bytes leave the CR tracking alone
                track = 1'b0;
                if (trailer_left <= 1)
                begin
                    trailer_left = '0;
                    restart_size_line();
                    ph = PH_SIZE;
                end
                else
                    trailer_left = trailer_left - 1'b1;
            end
            default:
                track = 1'b0;
        endcase
        if (track)
            cr_seen = (b == BYTE_CR);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [7:0] exp_val,
                                 input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph            = PH_HEADER;
            cr_seen       = 1'b0;
            crlf_run      = '0;
            restart_size_line();
            left_in_chunk = '0;
            trailer_left  = '0;
            decoded_q.delete();
            pending       = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer: expected none, %s%02h %s%03b %s%0b",
                             $time, "got tdata=", m_tdata, "tuser=", m_tuser,
                             "tlast=", m_tlast);
                    errors++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    compare_field("payload_valid", want.payload_valid, m_tuser[0]);
                    // non-payload results carry a zero byte
                    compare_field("payload_byte", want.payload_byte, m_tdata);
                    compare_field("chunk_last", want.chunk_last, m_tlast);
                    compare_field("body_done", want.body_done, m_tuser[1]);
                    compare_field("format_error", want.format_error, m_tuser[2]);
                end
            end
            if (s_tvalid && s_tready)
                decoded_q.push_back(decode_byte(s_tdata));
            pending = decoded_q.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the chunked body decoder a response stream: a short hand-made header
// and chunk sequence, then random chunks with odd size lines and trailers,
// under several sender and receiver stall mixes, ending the body at random
// by a zero-size chunk or a size line with no digits.
// ----------------------------------------------------------------------------
module tb_top;
    import chbd_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 600;
    localparam int HOLD_CYCLES  = 120;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic [USER_W-1:0] m_tuser;
    logic              m_tlast;
    int                pending;
    int                errors;

    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    bit    hold_go       = 1'b0;
    int    bytes_sent    = 0;
    int    chunks_sent   = 0;
    int    payload_sent  = 0;
    int    long_lines    = 0;
    string finish_kind;

    http_chunked_body_decoder_core dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    chbd_decode_checker u_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .pending  (pending),
        .errors   (errors)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("%0t: timeout with %0d results outstanding", $time, pending);
        $display("TEST FAILED");
        $finish;
    end

    // receiver: random backpressure, plus one long hold-off on request
    initial
    begin : receiver
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic push_crlf();
        push_byte(BYTE_CR);
        push_byte(BYTE_LF);
    endtask

    task automatic idle_until_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    function automatic logic [7:0] hex_char(input int nib);
        if (nib < 10)
            return "0" + 8'(nib);
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(nib - 10);
    endfunction

    function automatic logic [7:0] pick_stop_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")
               || c == BYTE_CR || c == BYTE_LF);
        return c;
    endfunction

    // chunk extension: non-hex start, then anything but a CR LF pair
    task automatic push_extension();
        logic [7:0] prev;
        logic [7:0] c;
        prev = pick_stop_char();
        push_byte(prev);
        repeat ($urandom_range(0, 4))
        begin
            c = $urandom_range(0, 1) ? hex_char($urandom_range(0, 15))
                                     : 8'($urandom_range(0, 255));
            if (prev == BYTE_CR && c == BYTE_LF)
                c = "x";
            push_byte(c);
            prev = c;
        end
    endtask

    task automatic push_size_line(input int value, input int ndig, input int extra,
                                  input bit with_ext);
        for (int i = ndig - 1; i >= 0; i--)
        begin
            // stray CR or LF between digits must be ignored
            if (i != ndig - 1 && $urandom_range(0, 19) == 0)
                push_byte($urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
            push_byte(hex_char((value >> (4 * i)) & 15));
        end
        repeat (extra) push_byte(hex_char($urandom_range(0, 15)));
        if (with_ext)
            push_extension();
        push_crlf();
    endtask

    task automatic push_chunk();
        int size;
        int r;
        int mind;
        int extra;
        r = $urandom_range(0, 99);
        if (r < 70)
            size = $urandom_range(1, 8);
        else if (r < 95)
            size = $urandom_range(9, 64);
        else
            size = $urandom_range(65, 300);
        mind  = (size > 255) ? 3 : (size > 15) ? 2 : 1;
        extra = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
        push_size_line(size, $urandom_range(mind, SIZE_DIGITS), extra,
                       $urandom_range(0, 6) == 0);
        repeat (size) push_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 6) == 0)
        begin
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(0, 255)));
        end
        else
            push_crlf();
        chunks_sent++;
        payload_sent += size;
        if (extra > 0)
            long_lines++;
    endtask

    initial
    begin : stimulus
        int quota;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // header: 0xFF, CR LF, bare LF resets the count, then the blank line
        push_byte(8'hFF);
        push_crlf();
        push_byte(BYTE_LF);
        push_crlf();
        push_crlf();
        // size 2 with text after the digit, data ends on a CR
        push_text("2g");
        push_crlf();
        push_byte(8'h00);
        push_byte(BYTE_CR);
        push_crlf();
        // stray LF and CR among digits, fifth digit is too many
        push_text("0");
        push_byte(BYTE_LF);
        push_text("0");
        push_byte(BYTE_CR);
        push_text("01F");
        push_crlf();
        push_byte(8'hFF);
        push_text("zz");
        chunks_sent  = 2;
        payload_sent = 3;
        long_lines   = 1;

        for (int p = 0; p < 3; p++)
        begin
            idle_until_drained();
            case (p)
                0:
                begin
                    send_idle_pct = 16;
                    recv_idle_pct = 47;
                end
                1:
                begin
                    send_idle_pct = 47;
                    recv_idle_pct = 16;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_go       = 1'b1;
                end
            endcase
            quota = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < quota)
                push_chunk();
        end

        if ($urandom_range(0, 1))
        begin
            finish_kind = "zero-size chunk";
            push_size_line(0, $urandom_range(1, SIZE_DIGITS), 0, $urandom_range(0, 1));
        end
        else
        begin
            finish_kind = "size line without digits";
            if ($urandom_range(0, 1))
                push_extension();
            push_crlf();
        end
        // decoder is stopped now, these must come out all zero
        repeat (4) push_byte(8'($urandom_range(0, 255)));

        idle_until_drained();
        repeat (5) @(negedge clk);

        $display("Sent %0d bytes: %0d chunks, %0d payload bytes, %0d size lines with surplus digits.",
                 bytes_sent, chunks_sent, payload_sent, long_lines);
        $display("Stall mixes in both directions, a %0d-cycle output hold-off, body ended by a %s.",
                 HOLD_CYCLES, finish_kind);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
